// ===== design/scf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scf_pkg
// Types and constants shared by the sysex chunk framer and its channels.
// ---------------------------------------------------------------------------
package scf_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned SIZE_W = 13;
   localparam int unsigned FILL_W = 12;

   localparam logic [DATA_W-1:0] START_BYTE = 8'hF0;
   localparam logic [DATA_W-1:0] END_BYTE   = 8'hF7;
   localparam logic [SIZE_W-1:0] MAX_CHUNK  = 13'd4096;
   localparam logic [SIZE_W-1:0] MIN_CHUNK  = 13'd1;
   localparam logic [SIZE_W-1:0] RESET_CHUNK = 13'd256;

   typedef enum logic [2:0] {
      PHASE_START = 3'b001,
      PHASE_DATA  = 3'b010,
      PHASE_END   = 3'b100
   } phase_type;

endpackage : scf_pkg
`default_nettype wire

// ===== design/scf_req_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scf_req_if
// Payload byte channel: one sysex payload byte per transaction.
// ---------------------------------------------------------------------------
interface scf_req_if
   import scf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface : scf_req_if
`default_nettype wire

// ===== design/scf_rsp_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scf_rsp_if
// Framed byte channel: one framed byte with chunk and message marks.
// ---------------------------------------------------------------------------
interface scf_rsp_if
   import scf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              chunk_last;
   logic              last_of_message;

   modport source (output valid, output out_byte, output chunk_last,
                   output last_of_message, input ready);
   modport sink   (input valid, input out_byte, input chunk_last,
                   input last_of_message, output ready);
endinterface : scf_rsp_if
`default_nettype wire

// ===== design/sysex_chunk_framer_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sysex_chunk_framer_unit
// Frames sysex payload bytes with 0xF0/0xF7 and cuts the stream into chunks.
// ---------------------------------------------------------------------------
// One framed byte leaves per cycle unless the receiver stalls. A payload byte
// in mid-message gives that byte alone; the first byte of a message gives
// 0xF0, then the byte, the last gives the byte, then 0xF7, and a one-byte
// message gives 0xF0, the byte, 0xF7. A holding register in front of the
// single output register takes the next transaction in the same cycle that
// the current one sends its final byte. The user writes chunk_size through
// csr_wr_en/csr_wr_data only while the block is idle; no check enforces it.
module sysex_chunk_framer_unit
   import scf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   scf_req_if.sink                req,
   scf_rsp_if.source              rsp,
   input  wire logic              csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0] chunk_size_ff;
   logic              in_message_ff, in_message_in;
   logic [FILL_W-1:0] chunk_fill_ff, chunk_fill_in;

   logic              hold_valid_ff, hold_valid_in;
   logic [DATA_W-1:0] hold_byte_ff;
   logic              hold_eom_ff;
   phase_type         phase_ff, phase_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_byte_ff, out_byte_in;
   logic              out_close_ff, out_close_in;
   logic              out_eom_ff, out_eom_in;

   logic              advance;
   logic              hold_done;
   logic              accept;
   logic [SIZE_W-1:0] eff_size;
   logic [SIZE_W-1:0] fill_next;

   // effective chunk size, clamped to 1..4096
   always_comb begin
      if (chunk_size_ff == '0) begin
         eff_size = MIN_CHUNK;
      end else if (chunk_size_ff > MAX_CHUNK) begin
         eff_size = MAX_CHUNK;
      end else begin
         eff_size = chunk_size_ff;
      end
   end

   assign advance   = hold_valid_ff && (!out_valid_ff || rsp.ready);
   assign hold_done = advance && ((phase_ff == PHASE_DATA && !hold_eom_ff) ||
                                  (phase_ff == PHASE_END));
   assign req.ready = !hold_valid_ff || hold_done;
   assign accept    = req.valid && req.ready;
   assign fill_next = {1'b0, chunk_fill_ff} + SIZE_W'(1);

   always_comb begin
      in_message_in = in_message_ff;
      chunk_fill_in = chunk_fill_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_byte_in   = out_byte_ff;
      out_close_in  = out_close_ff;
      out_eom_in    = out_eom_ff;
      phase_in      = phase_ff;
      hold_valid_in = hold_valid_ff && !hold_done;

      if (advance) begin
         out_valid_in = 1'b1;
         out_eom_in   = 1'b0;
         case (phase_ff)
            PHASE_START: begin
               out_byte_in   = START_BYTE;
               in_message_in = 1'b1;
               phase_in      = PHASE_DATA;
            end
            PHASE_DATA: begin
               out_byte_in = hold_byte_ff;
               phase_in    = PHASE_END;
            end
            PHASE_END: begin
               out_byte_in   = END_BYTE;
               out_eom_in    = 1'b1;
               in_message_in = 1'b0;
            end
            default: begin
               out_byte_in = hold_byte_ff;
            end
         endcase
         out_close_in = (phase_ff == PHASE_END) || (fill_next >= eff_size);
         if (out_close_in) begin
            chunk_fill_in = '0;
         end else begin
            chunk_fill_in = fill_next[FILL_W-1:0];
         end
      end

      if (accept) begin
         hold_valid_in = 1'b1;
         phase_in      = in_message_in ? PHASE_DATA : PHASE_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= RESET_CHUNK;
         in_message_ff <= 1'b0;
         chunk_fill_ff <= '0;
         hold_valid_ff <= 1'b0;
         phase_ff      <= PHASE_START;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chunk_size_ff <= csr_wr_data;
         end
         in_message_ff <= in_message_in;
         chunk_fill_ff <= chunk_fill_in;
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_byte_ff <= req.data_byte;
         hold_eom_ff  <= req.end_of_message;
      end
      out_byte_ff  <= out_byte_in;
      out_close_ff <= out_close_in;
      out_eom_ff   <= out_eom_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.out_byte        = out_byte_ff;
   assign rsp.chunk_last      = out_close_ff;
   assign rsp.last_of_message = out_eom_ff;

endmodule : sysex_chunk_framer_unit
`default_nettype wire

// ===== sim/scf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scf_checker
// Watches the payload and framed byte channels of the sysex chunk framer.
// Each accepted payload byte is framed and chunked by a local predictor that
// follows the chunk size register writes, and each accepted framed byte is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module scf_checker
   import scf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   scf_req_if                     req,
   scf_rsp_if                     rsp,
   input  wire logic              csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wr_data,
   output int                     errors,
   output int                     pending
);

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              chunk_last;
      logic              last_of_message;
   } framed_byte_type;

   framed_byte_type   framed_q[$];
   logic [SIZE_W-1:0] chunk_size;
   logic              in_message;
   logic [FILL_W-1:0] chunk_fill;
   int                fail_count = 0;

   function automatic logic [SIZE_W-1:0] chunk_span(input logic [SIZE_W-1:0] size);
      if (size == '0) return MIN_CHUNK;
      if (size > MAX_CHUNK) return MAX_CHUNK;
      return size;
   endfunction

   function automatic void emit_framed(input logic [DATA_W-1:0] b, input logic force_close,
                                       input logic msg_end);
      logic closes;
      closes = force_close || (({1'b0, chunk_fill} + 13'd1) >= chunk_span(chunk_size));
      framed_q.push_back('{out_byte: b, chunk_last: closes, last_of_message: msg_end});
      chunk_fill = closes ? '0 : chunk_fill + 1'b1;
   endfunction

   function automatic void frame_payload(input logic [DATA_W-1:0] b, input logic eom);
      if (!in_message) begin
         chunk_fill = '0;
         emit_framed(START_BYTE, 1'b0, 1'b0);
         in_message = 1'b1;
      end
      emit_framed(b, 1'b0, 1'b0);
      if (eom) begin
         emit_framed(END_BYTE, 1'b1, 1'b1);
         in_message = 1'b0;
         chunk_fill = '0;
      end
   endfunction

   always @(posedge clock) begin
      framed_byte_type want;
      framed_byte_type got;
      if (reset) begin
         chunk_size = RESET_CHUNK;
         in_message = 1'b0;
         chunk_fill = '0;
         framed_q.delete();
      end else begin
         if (csr_wr_en) chunk_size = csr_wr_data;
         if (req.valid && req.ready) frame_payload(req.data_byte, req.end_of_message);
         if (rsp.valid && rsp.ready) begin
            got = '{out_byte: rsp.out_byte, chunk_last: rsp.chunk_last,
                    last_of_message: rsp.last_of_message};
            if (framed_q.size() == 0) begin
               fail_count++;
               $display("%t: unexpected framed byte: expected none, actual %h/%b/%b",
                        $realtime, got.out_byte, got.chunk_last, got.last_of_message);
            end else begin
               want = framed_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%t: framed byte mismatch: expected %h/%b/%b, actual %h/%b/%b",
                           $realtime, want.out_byte, want.chunk_last, want.last_of_message,
                           got.out_byte, got.chunk_last, got.last_of_message);
               end
            end
         end
      end
      errors  <= fail_count;
      pending <= framed_q.size();
   end

endmodule : scf_checker

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the sysex chunk framer: directed messages at the chunk size
// extremes and a mid-message size change, then random messages over random
// chunk sizes with random idling on both channels and one long receiver stall.
// ---------------------------------------------------------------------------
module tb;
   import scf_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int CALM_TAIL      = 60;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   int                errors;
   int                pending;

   bit                calm = 1'b0;
   bit                squeeze = 1'b0;
   int                send_rate = 0;
   int                recv_rate = 0;
   int                msg_left = 0;

   scf_req_if req_ch ();
   scf_rsp_if rsp_ch ();

   sysex_chunk_framer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   scf_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending)
   );

   always #1 clock = ~clock;

   // payload transaction, with an optional idle burst in front
   task automatic send_payload(input logic [DATA_W-1:0] b, input logic eom);
      if (!calm && send_rate > 0 && $urandom_range(0, 99) < send_rate) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= b;
      req_ch.end_of_message <= eom;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_and_set_size(input logic [SIZE_W-1:0] size);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return SIZE_W'($urandom_range(1, 6));
         6:                return '0;
         7:                return SIZE_W'($urandom_range(7, 40));
         8:                return $urandom_range(0, 1) ? MAX_CHUNK
                                                       : SIZE_W'($urandom_range(4097, 8191));
         default:          return RESET_CHUNK;
      endcase
   endfunction

   // receiver
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (squeeze) begin
            squeeze = 1'b0;
            stall_left = 79;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && recv_rate > 0 && $urandom_range(0, 99) < recv_rate) begin
            stall_left = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int sent;
      int phase_items;
      sent = 0;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.data_byte      <= '0;
      req_ch.end_of_message <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset size, one-byte message
      send_payload(8'h00, 1'b1);
      drain_and_set_size(13'd1);
      send_payload(8'hFF, 1'b0);
      send_payload(8'h55, 1'b1);
      // zero size acts as one
      drain_and_set_size(13'd0);
      send_payload(8'hAA, 1'b1);
      drain_and_set_size(13'd2);
      send_payload(8'h01, 1'b0);
      send_payload(8'h02, 1'b0);
      send_payload(8'h80, 1'b1);
      // size shrinks below the open chunk fill mid-message
      drain_and_set_size(13'd8);
      send_payload(8'h10, 1'b0);
      send_payload(8'h20, 1'b0);
      send_payload(8'h30, 1'b0);
      send_payload(8'h40, 1'b0);
      send_payload(8'h7F, 1'b0);
      drain_and_set_size(13'd3);
      send_payload(8'hE5, 1'b1);
      // oversize values saturate
      drain_and_set_size(13'd4097);
      send_payload(START_BYTE, 1'b0);
      send_payload(END_BYTE, 1'b1);
      drain_and_set_size(13'd8191);
      send_payload(8'h5A, 1'b0);
      send_payload(8'hA5, 1'b1);
      drain_and_set_size(MAX_CHUNK);
      send_payload(8'hC3, 1'b1);
      // end byte alone in the final chunk
      drain_and_set_size(13'd3);
      send_payload(8'h01, 1'b0);
      send_payload(8'h02, 1'b1);

      // random phases
      while (sent < RANDOM_ITEMS) begin
         drain_and_set_size(pick_size());
         send_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         recv_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         if (sent == 0) squeeze = 1'b1;
         phase_items = $urandom_range(8, 40);
         repeat (phase_items) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                      : $urandom_range(1, 10);
            if (sent >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
            send_payload(8'($urandom_range(0, 255)), msg_left == 1);
            msg_left--;
            sent++;
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : tb

// ===== sysex_chunk_framer_unit.f =====
design/scf_pkg.sv
design/scf_req_if.sv
design/scf_rsp_if.sv
design/sysex_chunk_framer_unit.sv
sim/scf_checker.sv
sim/tb.sv
